FILE: src/wqtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wqtp_pkg
// Shared types, constants and helpers of the window quality trim point unit.
// ----------------------------------------------------------------------------
package wqtp_pkg;

  localparam int MAX_LINE     = 8192;
  localparam int MAX_WINDOW   = 16;
  localparam int SCORE_OFFSET = 33;

  localparam int BYTE_W    = 8;
  localparam int SCORE_W   = 9;
  localparam int SUM_W     = 13;
  localparam int POS_W     = $clog2(MAX_LINE + 1);
  localparam int START_W   = $clog2(MAX_LINE);
  localparam int WIN_W     = 5;
  localparam int WIN_IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int QUAL_W    = 7;
  localparam int LEN_W     = 14;
  localparam int THR_W     = QUAL_W + WIN_W;
  localparam int OUTC_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_QUALITY = 2'd0,
    REG_MIN_LENGTH  = 2'd1,
    REG_WINDOW_SIZE = 2'd2
  } cfg_reg_t;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_KEEP    = 2'd0,
    OUTC_TRIM    = 2'd1,
    OUTC_DISCARD = 2'd2
  } outcome_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic               load;
    logic               failure_seen;
    logic [START_W-1:0] failure_start;
    logic [POS_W-1:0]   position;
    logic [LEN_W-1:0]   min_length;
  } read_summary_t;

  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    r = w;
    if (w == '0) r = WIN_W'(1);
    else if (w > WIN_W'(MAX_WINDOW)) r = WIN_W'(MAX_WINDOW);
    return r;
  endfunction

  function automatic logic [QUAL_W-1:0] eff_quality(input logic [QUAL_W-1:0] q);
    return (q == '0) ? QUAL_W'(1) : q;
  endfunction

endpackage

FILE: src/window_quality_trim_point_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_quality_trim_point_unit
// Finds the first sliding window of a read whose mean quality falls below
// the threshold and gives one keep, trim or discard verdict per read.
//
//   channel  direction  payload
//   in_      slave      tdata[7:0] quality_byte, tlast last
//   out_     master     tdata[1:0] outcome, [15:2] keep_length,
//                       [29:16] read_length, [31:30] zero
//   cfg_     slave      cfg_index register, cfg_data value
//
// One quality byte is taken in every cycle; the row of score cells updates
// all window sums in that cycle. A verdict appears in the cycle after the last
// byte. The result register lets the next read stream in while a verdict
// waits; input stalls only when a new verdict meets one not yet taken.
// Synchronous reset sets config defaults, clears scan state, cells and valid.
// ----------------------------------------------------------------------------
module window_quality_trim_point_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wqtp_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] quality_byte
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wqtp_pkg::OUT_DATA_W-1:0]     out_tdata,  // outcome, keep_length,
                                                          // read_length
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wqtp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wqtp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NC = wqtp_pkg::MAX_WINDOW;

  logic [wqtp_pkg::QUAL_W-1:0]  min_q_r, min_q_nxt;
  logic [wqtp_pkg::LEN_W-1:0]   min_len_r, min_len_nxt;
  logic [wqtp_pkg::WIN_W-1:0]   win_r, win_nxt;
  logic [wqtp_pkg::THR_W-1:0]   thr_r, thr_nxt;
  logic [wqtp_pkg::WIN_W-1:0]   eff_w, eff_w_nxt;
  logic [wqtp_pkg::WIN_IDX_W-1:0] sel;

  logic [wqtp_pkg::POS_W-1:0]   pos_r, pos_step, pos_nxt;
  logic                         fail_r, fail_hit, fail_nxt;
  logic [wqtp_pkg::START_W-1:0] start_r, start_nxt;

  logic                         accept, advance, last_acc, load_ready;
  logic signed [wqtp_pkg::SCORE_W-1:0] new_score;
  logic signed [wqtp_pkg::SCORE_W-1:0] score_chain [NC];
  logic signed [wqtp_pkg::SUM_W-1:0]   sum_cell [NC];
  logic signed [wqtp_pkg::SUM_W-1:0]   sum_sel;
  logic [wqtp_pkg::POS_W-1:0]   w_ext;
  wqtp_pkg::cell_ctl_t          ctl;
  wqtp_pkg::read_summary_t      summary;

  // configuration
  assign cfg_ready = 1'b1;

  always_comb begin
    min_q_nxt   = min_q_r;
    min_len_nxt = min_len_r;
    win_nxt     = win_r;
    if (cfg_valid) begin
      case (cfg_index)
        wqtp_pkg::REG_MIN_QUALITY: min_q_nxt   = cfg_data[wqtp_pkg::QUAL_W-1:0];
        wqtp_pkg::REG_MIN_LENGTH:  min_len_nxt = cfg_data[wqtp_pkg::LEN_W-1:0];
        wqtp_pkg::REG_WINDOW_SIZE: win_nxt     = cfg_data[wqtp_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
    eff_w_nxt = wqtp_pkg::eff_window(win_nxt);
    thr_nxt   = wqtp_pkg::THR_W'(wqtp_pkg::eff_quality(min_q_nxt))
              * wqtp_pkg::THR_W'(eff_w_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_q_r   <= wqtp_pkg::QUAL_W'(10);
      min_len_r <= wqtp_pkg::LEN_W'(25);
      win_r     <= wqtp_pkg::WIN_W'(4);
      thr_r     <= wqtp_pkg::THR_W'(40);
    end else begin
      min_q_r   <= min_q_nxt;
      min_len_r <= min_len_nxt;
      win_r     <= win_nxt;
      thr_r     <= thr_nxt;
    end
  end

  assign eff_w = wqtp_pkg::eff_window(win_r);
  assign sel   = wqtp_pkg::WIN_IDX_W'(eff_w - wqtp_pkg::WIN_W'(1));
  assign w_ext = wqtp_pkg::POS_W'(eff_w);

  // input side: only a last byte waits for the result register
  assign in_tready = !in_tlast || load_ready;
  assign accept    = in_tvalid && in_tready;
  assign last_acc  = accept && in_tlast;
  assign advance   = accept && (pos_r < wqtp_pkg::POS_W'(wqtp_pkg::MAX_LINE));
  assign new_score = $signed({1'b0, in_tdata})
                   - wqtp_pkg::SCORE_W'(wqtp_pkg::SCORE_OFFSET);

  assign ctl.advance = advance;
  assign ctl.clear   = last_acc;

  genvar g;
  generate
    for (g = 0; g < NC; g++) begin : g_cell
      logic signed [wqtp_pkg::SCORE_W-1:0] score_from;
      if (g == 0) begin : g_head
        assign score_from = new_score;
      end else begin : g_body
        assign score_from = score_chain[g-1];
      end
      wqtp_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_score (new_score),
        .score_in  (score_from),
        .score_out (score_chain[g]),
        .sum_nxt   (sum_cell[g])
      );
    end
  endgenerate

  assign sum_sel  = sum_cell[sel];
  assign pos_step = pos_r + wqtp_pkg::POS_W'(1);

  always_comb begin
    fail_hit = advance && !fail_r && (pos_step >= w_ext)
            && (pos_step < wqtp_pkg::POS_W'(wqtp_pkg::MAX_LINE))
            && ($signed({sum_sel[wqtp_pkg::SUM_W-1], sum_sel}) < $signed({2'b00, thr_r}));
    fail_nxt  = fail_r || fail_hit;
    start_nxt = fail_hit ? wqtp_pkg::START_W'(pos_step - w_ext) : start_r;
    pos_nxt   = advance ? pos_step : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || last_acc) begin
      pos_r   <= '0;
      fail_r  <= 1'b0;
      start_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      fail_r  <= fail_nxt;
      start_r <= start_nxt;
    end
  end

  assign summary.load          = last_acc;
  assign summary.failure_seen  = fail_nxt;
  assign summary.failure_start = start_nxt;
  assign summary.position      = pos_nxt;
  assign summary.min_length    = min_len_r;

  wqtp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .summary    (summary),
    .load_ready (load_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: src/wqtp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wqtp_cell
// One score slot with the running sum of the newest scores up to this slot.
// ----------------------------------------------------------------------------
module wqtp_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wqtp_pkg::cell_ctl_t                 ctl,
  input  logic signed [wqtp_pkg::SCORE_W-1:0] new_score,
  input  logic signed [wqtp_pkg::SCORE_W-1:0] score_in,
  output logic signed [wqtp_pkg::SCORE_W-1:0] score_out,
  output logic signed [wqtp_pkg::SUM_W-1:0]   sum_nxt
);

  logic signed [wqtp_pkg::SCORE_W-1:0] score_r;
  logic signed [wqtp_pkg::SUM_W-1:0]   sum_r;

  assign sum_nxt = sum_r
                 + wqtp_pkg::SUM_W'(new_score)
                 - wqtp_pkg::SUM_W'(score_r);
  assign score_out = score_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      score_r <= '0;
      sum_r   <= '0;
    end else if (ctl.advance) begin
      score_r <= score_in;
      sum_r   <= sum_nxt;
    end
  end

endmodule

FILE: src/wqtp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wqtp_out_stage
// Verdict decision and output register of the result channel.
// ----------------------------------------------------------------------------
module wqtp_out_stage (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wqtp_pkg::read_summary_t              summary,
  output logic                                 load_ready,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [wqtp_pkg::OUT_DATA_W-1:0]      out_tdata
);

  logic                          valid_r;
  logic [wqtp_pkg::OUTC_W-1:0]   outcome_r;
  logic [wqtp_pkg::LEN_W-1:0]    keep_r;
  logic [wqtp_pkg::LEN_W-1:0]    length_r;
  logic [wqtp_pkg::OUTC_W-1:0]   outcome_nxt;
  logic [wqtp_pkg::LEN_W-1:0]    keep_nxt;
  logic [wqtp_pkg::LEN_W-1:0]    start_ext;

  assign load_ready = !valid_r || out_tready;
  assign start_ext  = wqtp_pkg::LEN_W'(summary.failure_start);

  always_comb begin
    if (!summary.failure_seen) begin
      outcome_nxt = wqtp_pkg::OUTC_KEEP;
      keep_nxt    = wqtp_pkg::LEN_W'(summary.position);
    end else if (start_ext < summary.min_length) begin
      outcome_nxt = wqtp_pkg::OUTC_DISCARD;
      keep_nxt    = '0;
    end else begin
      outcome_nxt = wqtp_pkg::OUTC_TRIM;
      keep_nxt    = start_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (summary.load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (summary.load) begin
      outcome_r <= outcome_nxt;
      keep_r    <= keep_nxt;
      length_r  <= wqtp_pkg::LEN_W'(summary.position);
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {
    {(wqtp_pkg::OUT_DATA_W - wqtp_pkg::OUTC_W - 2 * wqtp_pkg::LEN_W){1'b0}},
    length_r, keep_r, outcome_r
  };

endmodule

FILE: src/wqtp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wqtp_checker
// Port-level checks on the verdict stream of the trim point unit.
// ----------------------------------------------------------------------------
module wqtp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wqtp_pkg::OUT_DATA_W-1:0]  out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != wqtp_pkg::OUTC_W'(3))
    else $error("bad outcome code");

  a_discard: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == wqtp_pkg::OUTC_DISCARD |-> out_tdata[15:2] == 14'd0)
    else $error("discard with nonzero keep length");

  a_keep_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:2] <= out_tdata[29:16])
    else $error("keep length exceeds read length");

endmodule

bind window_quality_trim_point_unit wqtp_checker u_wqtp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/window_quality_trim_point_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_quality_trim_point_unit_test
// Streams quality strings into the trim point unit read by read. A scan model
// in the bench follows every accepted character and queues the verdict due
// at each last character. Each verdict transfer is checked field by field.
// The run covers register extremes, short and long reads, back-to-back
// verdicts and random reads, with random gaps on both streams.
// ----------------------------------------------------------------------------
module window_quality_trim_point_unit_test;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int IDLE_PCT     = 12;
  localparam int RANDOM_ITEMS = 1350;

  typedef struct {
    wqtp_pkg::outcome_t         outcome;
    logic [wqtp_pkg::LEN_W-1:0] keep_length;
    logic [wqtp_pkg::LEN_W-1:0] read_length;
  } verdict_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [wqtp_pkg::BYTE_W-1:0]     in_tdata   = '0;   // [7:0] quality_byte
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [wqtp_pkg::OUT_DATA_W-1:0] out_tdata;  // [1:0] outcome, [15:2] keep_length,
                                               // [29:16] read_length
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  wqtp_pkg::cfg_reg_t              cfg_index  = wqtp_pkg::REG_MIN_QUALITY;
  logic [wqtp_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  // scan model state and register copies
  logic [wqtp_pkg::QUAL_W-1:0] min_qual_reg = wqtp_pkg::QUAL_W'(10);
  logic [wqtp_pkg::LEN_W-1:0]  min_len_reg  = wqtp_pkg::LEN_W'(25);
  logic [wqtp_pkg::WIN_W-1:0]  win_reg      = wqtp_pkg::WIN_W'(4);
  int                scores [wqtp_pkg::MAX_WINDOW] = '{default: 0};
  int                read_pos   = 0;
  bit                fail_seen  = 1'b0;
  int                fail_start = 0;
  verdict_t          verdict_q[$];
  verdict_t          due;

  logic [7:0]        read_buf[$];
  bit                send_gaps  = 1'b1;
  bit                take_gaps  = 1'b1;
  int                mismatches = 0;
  int                cycle_count = 0;

  window_quality_trim_point_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= !take_gaps || ($urandom_range(99) >= IDLE_PCT);

  function automatic void scan_quality(logic [7:0] qchar, logic lst);
    int       w;
    int       q;
    int       sum;
    int       i;
    verdict_t v;
    w = (win_reg == '0) ? 1
      : (win_reg > wqtp_pkg::MAX_WINDOW) ? wqtp_pkg::MAX_WINDOW : int'(win_reg);
    q = (min_qual_reg == '0) ? 1 : int'(min_qual_reg);
    if (read_pos < wqtp_pkg::MAX_LINE) begin
      for (i = wqtp_pkg::MAX_WINDOW - 1; i > 0; i--) scores[i] = scores[i-1];
      scores[0] = int'(qchar) - wqtp_pkg::SCORE_OFFSET;
      sum = 0;
      for (i = 0; i < w; i++) sum += scores[i];
      read_pos++;
      // windows ending at the line limit are not scanned
      if (!fail_seen && read_pos >= w && read_pos < wqtp_pkg::MAX_LINE && sum < q * w) begin
        fail_seen  = 1'b1;
        fail_start = read_pos - w;
      end
    end
    if (lst) begin
      if (!fail_seen) begin
        v.outcome     = wqtp_pkg::OUTC_KEEP;
        v.keep_length = wqtp_pkg::LEN_W'(read_pos);
      end else if (fail_start < int'(min_len_reg)) begin
        v.outcome     = wqtp_pkg::OUTC_DISCARD;
        v.keep_length = '0;
      end else begin
        v.outcome     = wqtp_pkg::OUTC_TRIM;
        v.keep_length = wqtp_pkg::LEN_W'(fail_start);
      end
      v.read_length = wqtp_pkg::LEN_W'(read_pos);
      verdict_q.push_back(v);
      for (i = 0; i < wqtp_pkg::MAX_WINDOW; i++) scores[i] = 0;
      read_pos   = 0;
      fail_seen  = 1'b0;
      fail_start = 0;
    end
  endfunction

  // check verdicts before taking this edge's character
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected verdict transfer: %h", out_tdata);
        end else begin
          due = verdict_q.pop_front();
          if (out_tdata[1:0] !== due.outcome || out_tdata[15:2] !== due.keep_length ||
              out_tdata[29:16] !== due.read_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("verdict mismatch: expected outcome %0d keep %0d length %0d, ",
                       due.outcome, due.keep_length, due.read_length,
                       "got outcome %0d keep %0d length %0d",
                       out_tdata[1:0], out_tdata[15:2], out_tdata[29:16]);
          end
        end
      end
      if (in_tvalid && in_tready) scan_quality(in_tdata, in_tlast);
    end
  end

  function automatic logic [7:0] q_char(int score);
    int c;
    c = score + wqtp_pkg::SCORE_OFFSET;
    return (c < 0) ? 8'd0 : (c > 255) ? 8'd255 : 8'(c);
  endfunction

  task automatic fill_read(int len, int score);
    repeat (len) read_buf.push_back(q_char(score));
  endtask

  task automatic send_read();
    int i;
    for (i = 0; i < read_buf.size(); i++) begin
      while (send_gaps && $urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= read_buf[i];
      in_tlast  <= (i == read_buf.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    read_buf.delete();
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(wqtp_pkg::cfg_reg_t idx, logic [wqtp_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      wqtp_pkg::REG_MIN_QUALITY: min_qual_reg = value[wqtp_pkg::QUAL_W-1:0];
      wqtp_pkg::REG_MIN_LENGTH:  min_len_reg  = value[wqtp_pkg::LEN_W-1:0];
      wqtp_pkg::REG_WINDOW_SIZE: win_reg      = value[wqtp_pkg::WIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int qual, int min_len, int win);
    write_reg(wqtp_pkg::REG_MIN_QUALITY, wqtp_pkg::CFG_DATA_W'(qual));
    write_reg(wqtp_pkg::REG_MIN_LENGTH, wqtp_pkg::CFG_DATA_W'(min_len));
    write_reg(wqtp_pkg::REG_WINDOW_SIZE, wqtp_pkg::CFG_DATA_W'(win));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    fill_read(3, 0);   // shorter than the window: kept whole
    send_read();
    fill_read(4, 2);   // fails at start 0, under min_length: discarded
    send_read();
    wait_idle();
  endtask

  task automatic test_trim_point();
    program_regs(10, 2, 4);
    fill_read(3, 30);
    fill_read(4, 0);
    fill_read(1, 30);
    send_read();
    wait_idle();
  endtask

  task automatic test_register_extremes();
    program_regs(0, 0, 0);
    read_buf.push_back(8'd33);   // trim at start zero with keep length zero
    send_read();
    read_buf.push_back(8'd0);
    read_buf.push_back(8'd255);
    send_read();
    wait_idle();
    program_regs(127, 16383, 31);
    read_buf.push_back(8'd255);
    read_buf.push_back(8'd0);
    send_read();
    wait_idle();
    program_regs(93, 8192, 1);
    read_buf.push_back(8'd126);
    read_buf.push_back(8'd125);
    send_read();
    wait_idle();
  endtask

  task automatic test_long_reads();
    program_regs(20, 0, 4);
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    // long stretch with no gaps on either stream
    fill_read(260, 40);
    fill_read(4, 0);
    fill_read(40, 40);
    send_read();
    fill_read(200, 40);
    send_read();
    wait_idle();
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    program_regs(20, 16383, 4);
    fill_read(10, 0);
    send_read();
    wait_idle();
  endtask

  task automatic test_verdict_backpressure();
    program_regs(30, 0, 1);
    send_gaps = 1'b0;
    repeat (24) begin
      read_buf.push_back(8'($urandom_range(255)));
      send_read();
    end
    wait_idle();
    send_gaps = 1'b1;
  endtask

  task automatic build_random_read();
    int len;
    int mode;
    int base;
    int dip_at;
    int dip_len;
    int i;
    len     = ($urandom_range(9) < 8) ? int'($urandom_range(1, 32))
                                      : int'($urandom_range(33, 160));
    mode    = $urandom_range(9);
    base    = $urandom_range(5, 50);
    dip_at  = $urandom_range(0, len - 1);
    dip_len = ($urandom_range(2) == 0) ? 0 : int'($urandom_range(1, 6));
    for (i = 0; i < len; i++) begin
      if (mode < 6) begin
        if (i >= dip_at && i < dip_at + dip_len)
          read_buf.push_back(q_char(int'($urandom_range(0, 8))));
        else
          read_buf.push_back(q_char(base + int'($urandom_range(0, 10)) - 5));
      end else if (mode < 8) begin
        read_buf.push_back(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(5))
          0:       read_buf.push_back(8'd0);
          1:       read_buf.push_back(8'd32);
          2:       read_buf.push_back(8'd33);
          3:       read_buf.push_back(8'd127);
          4:       read_buf.push_back(8'd128);
          default: read_buf.push_back(8'd255);
        endcase
      end
    end
  endtask

  task automatic test_random_reads();
    int items_sent;
    int qual;
    int min_len;
    int win;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       qual = 0;
        1:       qual = 127;
        2:       qual = 93;
        default: qual = $urandom_range(1, 45);
      endcase
      case ($urandom_range(9))
        0:       win = 0;
        1:       win = 31;
        2:       win = $urandom_range(17, 30);
        3:       win = 16;
        default: win = $urandom_range(1, 8);
      endcase
      case ($urandom_range(9))
        0:       min_len = 0;
        1:       min_len = 16383;
        2:       min_len = 8192;
        default: min_len = $urandom_range(0, 40);
      endcase
      program_regs(qual, min_len, win);
      repeat ($urandom_range(4, 12)) begin
        build_random_read();
        items_sent += read_buf.size();
        send_read();
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_trim_point();
    test_register_extremes();
    test_long_reads();
    test_verdict_backpressure();
    test_random_reads();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
